@@ hw/rtl/mcck_pkg.sv @@
// Package for the exact-k-runs min-cost coloring block.
// Holds cost widths, the infinity sentinel, register addresses and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package mcck_pkg;

  localparam int COST_W  = 30;
  localparam int TBL_W   = 38;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [TBL_W-1:0] INF_COST = {TBL_W{1'b1}};

  // register byte addresses
  localparam logic [CFG_AW-1:0] ADDR_NUM_COLORS  = 3'd0;
  localparam logic [CFG_AW-1:0] ADDR_TARGET_RUNS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SWEEP  = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

@@ hw/rtl/min_cost_coloring_k_runs_top.sv @@
// Top level of the exact-k-runs min-cost coloring block.
// Uses mcck_pkg. Table and cost buffer are inferred memories inside this module.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | fixed_color, color, paint_cost, position flags
//  out_    | output    | out_valid/out_stall | min_cost, feasible
//  cfg     | input     | APB psel/penable    | num_colors (0x0), target_runs (0x4)
//
// A transaction without last_color only writes the cost buffer.
// A last_color transaction makes one read-compute-write pass of the (color, runs) table
// memory, one entry per cycle, through a single compare/add unit, then drains the
// pipeline and ends in the finish state; with nc or nr zero it goes straight to finish.
// Reset is synchronous; the table needs no clearing pass (extent registers mark it empty).
// A result waits in the output register under out_stall; the next row may start meanwhile.
`timescale 1ns / 1ps
module min_cost_coloring_k_runs_top #(
  parameter int MAX_COLORS = 128,
  parameter int MAX_RUNS   = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_fixed_color,
  input  logic [7:0]                   in_color,
  input  logic [mcck_pkg::COST_W-1:0]  in_paint_cost,
  input  logic                         in_first_position,
  input  logic                         in_last_color,
  input  logic                         in_last_position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mcck_pkg::TBL_W-1:0]   out_min_cost,
  output logic                         out_feasible,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mcck_pkg::CFG_AW-1:0]  paddr,
  input  logic [mcck_pkg::CFG_DW-1:0]  pwdata,
  output logic [mcck_pkg::CFG_DW-1:0]  prdata,
  output logic                         pready
);
  import mcck_pkg::*;

  localparam int CW  = $clog2(MAX_COLORS);
  localparam int RW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int CXW = ($clog2(MAX_COLORS + 1) > 8) ? $clog2(MAX_COLORS + 1) : 8;
  localparam int RXW = ($clog2(MAX_RUNS + 1) > 8) ? $clog2(MAX_RUNS + 1) : 8;
  localparam int TBL_DEPTH = 2 ** (CW + RW);

  // configuration
  logic [7:0] num_colors_r, target_runs_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    prdata = '0;
    case (paddr)
      ADDR_NUM_COLORS:  prdata = CFG_DW'(num_colors_r);
      ADDR_TARGET_RUNS: prdata = CFG_DW'(target_runs_r);
      default:          prdata = '0;
    endcase
  end

  // memories
  logic [COST_W-1:0] cost_mem [0:MAX_COLORS-1];
  logic [TBL_W-1:0]  tbl_mem  [0:TBL_DEPTH-1];
  logic [COST_W-1:0] cost_rd_r;
  logic [TBL_W-1:0]  tbl_rd_r;

  // control
  state_t         state_r, state_nxt;
  logic           issuing_r;
  logic [CW-1:0]  ij_r;
  logic [RW-1:0]  ir_r;
  logic           s2_v_r;
  logic [CW-1:0]  s2_j_r;
  logic [RW-1:0]  s2_r_r;
  logic [CXW-1:0] nc_r, ext_c_r;
  logic [RXW-1:0] nr_r, ext_r_r;
  logic [7:0]     fixed_r;
  logic           first_r, lastp_r, tgt_ok_r;
  logic           out_valid_r, out_feas_r;
  logic [TBL_W-1:0] out_cost_r;

  // row statistics: accumulating (acc) and finished previous row (pb)
  logic [TBL_W-1:0] acc1_r, acc2_r, pb1_r, pb2_r, ans_r;
  logic [CW-1:0]    accidx_r, pidx_r;

  logic in_acc, out_free;
  logic [CXW-1:0] nc_eff, colx;
  logic [RXW-1:0] nr_eff, tx;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid & ~in_stall;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign out_valid    = out_valid_r;
  assign out_min_cost = out_cost_r;
  assign out_feasible = out_feas_r;

  always_comb begin
    nc_eff = CXW'(num_colors_r);
    if (nc_eff > CXW'(MAX_COLORS)) nc_eff = CXW'(MAX_COLORS);
    tx     = RXW'(target_runs_r);
    nr_eff = (tx > RXW'(MAX_RUNS)) ? RXW'(MAX_RUNS) : tx;
    colx   = CXW'(in_color);
  end

  // stage-2 compute: one table entry per cycle
  logic [TBL_W-1:0] prev_val, excl, m, new_val, a1_nxt, a2_nxt;
  logic [CW-1:0]    aidx_nxt;
  logic [TBL_W:0]   sum;
  logic             row_first, row_last, fix_hit, ans_row;

  always_comb begin
    row_first = (s2_j_r == '0);
    row_last  = (CXW'(s2_j_r) + CXW'(1) == nc_r);
    ans_row   = (RXW'(s2_r_r) + RXW'(1) == nr_r);
    fix_hit   = (CXW'(s2_j_r) + CXW'(1) == CXW'(fixed_r));
    prev_val  = ((CXW'(s2_j_r) < ext_c_r) && (RXW'(s2_r_r) < ext_r_r)) ? tbl_rd_r : INF_COST;
    excl      = (s2_r_r == '0) ? INF_COST : ((s2_j_r == pidx_r) ? pb2_r : pb1_r);
    m         = (prev_val < excl) ? prev_val : excl;
    sum       = {1'b0, m} + (TBL_W+1)'(cost_rd_r);
    if (first_r) begin
      if (s2_r_r != '0)         new_val = INF_COST;
      else if (fixed_r == '0)   new_val = TBL_W'(cost_rd_r);
      else                      new_val = fix_hit ? '0 : INF_COST;
    end else if (fixed_r != '0) begin
      new_val = fix_hit ? m : INF_COST;
    end else if (m == INF_COST) begin
      new_val = INF_COST;
    end else if (sum >= (TBL_W+1)'(INF_COST)) begin
      new_val = INF_COST - TBL_W'(1);
    end else begin
      new_val = sum[TBL_W-1:0];
    end
    // best and second best of the old row values
    a1_nxt   = row_first ? INF_COST : acc1_r;
    a2_nxt   = row_first ? INF_COST : acc2_r;
    aidx_nxt = row_first ? '0 : accidx_r;
    if (prev_val < a1_nxt) begin
      a2_nxt   = a1_nxt;
      a1_nxt   = prev_val;
      aidx_nxt = s2_j_r;
    end else if (prev_val < a2_nxt) begin
      a2_nxt = prev_val;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_last_color)
          state_nxt = (nc_eff != '0 && nr_eff != '0) ? ST_SWEEP : ST_FINISH;
      end
      ST_SWEEP: begin
        if (!issuing_r && !s2_v_r) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!lastp_r || out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (in_acc && colx >= CXW'(1) && colx <= CXW'(MAX_COLORS))
      cost_mem[CW'(colx - CXW'(1))] <= in_paint_cost;
    cost_rd_r <= cost_mem[ij_r];
    if (s2_v_r) tbl_mem[{s2_j_r, s2_r_r}] <= new_val;
    tbl_rd_r <= tbl_mem[{ij_r, ir_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      num_colors_r  <= 8'd1;
      target_runs_r <= 8'd1;
      issuing_r     <= 1'b0;
      s2_v_r        <= 1'b0;
      ext_c_r       <= '0;
      ext_r_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && paddr == ADDR_NUM_COLORS)  num_colors_r  <= pwdata[7:0];
      if (cfg_wr && paddr == ADDR_TARGET_RUNS) target_runs_r <= pwdata[7:0];
      s2_v_r <= issuing_r && (state_r == ST_SWEEP);
      if (state_r == ST_IDLE && in_acc && in_last_color)
        issuing_r <= (nc_eff != '0 && nr_eff != '0);
      else if (state_r == ST_SWEEP && issuing_r &&
               CXW'(ij_r) + CXW'(1) == nc_r && RXW'(ir_r) + RXW'(1) == nr_r)
        issuing_r <= 1'b0;
      if (state_r == ST_FINISH) begin
        ext_c_r <= nc_r;
        ext_r_r <= nr_r;
      end
      if (state_r == ST_FINISH && lastp_r && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE) begin
      ij_r <= '0;
      ir_r <= '0;
      if (in_acc && in_last_color) begin
        fixed_r  <= in_fixed_color;
        first_r  <= in_first_position;
        lastp_r  <= in_last_position;
        nc_r     <= nc_eff;
        nr_r     <= nr_eff;
        tgt_ok_r <= (target_runs_r != '0) && (tx <= RXW'(MAX_RUNS));
        ans_r    <= INF_COST;
      end
    end else if (state_r == ST_SWEEP && issuing_r) begin
      s2_j_r <= ij_r;
      s2_r_r <= ir_r;
      if (CXW'(ij_r) + CXW'(1) == nc_r) begin
        ij_r <= '0;
        ir_r <= ir_r + RW'(1);
      end else begin
        ij_r <= ij_r + CW'(1);
      end
    end
    if (s2_v_r) begin
      acc1_r   <= a1_nxt;
      acc2_r   <= a2_nxt;
      accidx_r <= aidx_nxt;
      if (row_last) begin
        pb1_r  <= a1_nxt;
        pb2_r  <= a2_nxt;
        pidx_r <= aidx_nxt;
      end
      if (ans_row && new_val < ans_r) ans_r <= new_val;
    end
    if (state_r == ST_FINISH && lastp_r && out_free) begin
      out_feas_r <= tgt_ok_r && (ans_r != INF_COST);
      out_cost_r <= (tgt_ok_r && (ans_r != INF_COST)) ? ans_r : '0;
    end
  end

endmodule

@@ hw/rtl/mcck_checker.sv @@
// Port-level checker for min_cost_coloring_k_runs_top, attached by bind.
// Uses mcck_pkg for field widths.
`timescale 1ns / 1ps
module mcck_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_last_color,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mcck_pkg::TBL_W-1:0]  out_min_cost,
  input logic                        out_feasible
);
  import mcck_pkg::*;

  // a transaction that only loads a cost leaves the block ready
  a_cost_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !in_last_color) |=> !in_stall)
    else $error("block not ready after cost-only transaction");

  // the position evaluation always occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last_color) |=> in_stall)
    else $error("block ready right after last_color transaction");

  // infeasible result carries zero cost
  a_infeasible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_feasible) |-> (out_min_cost == '0))
    else $error("infeasible result with nonzero cost");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_min_cost)))
    else $error("stalled result dropped or changed");

endmodule

bind min_cost_coloring_k_runs_top mcck_checker u_mcck_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_last_color (in_last_color),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_min_cost  (out_min_cost),
  .out_feasible  (out_feasible)
);

@@ sim/min_cost_coloring_k_runs_checker.sv @@
// Scoreboard for the exact-k-runs min-cost coloring block: follows register writes,
// predicts each row's answer from the accepted input transactions and compares results.
// Depends on mcck_pkg.
`timescale 1ns / 1ps
module min_cost_coloring_k_runs_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [7:0]                  in_fixed_color,
  input  logic [7:0]                  in_color,
  input  logic [mcck_pkg::COST_W-1:0] in_paint_cost,
  input  logic                        in_first_position,
  input  logic                        in_last_color,
  input  logic                        in_last_position,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [mcck_pkg::TBL_W-1:0]  out_min_cost,
  input  logic                        out_feasible,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [mcck_pkg::CFG_AW-1:0] paddr,
  input  logic [mcck_pkg::CFG_DW-1:0] pwdata,
  output int                          errors,
  output int                          pending
);
  import mcck_pkg::*;

  localparam int NCOL  = 128;
  localparam int NRUN  = 128;
  localparam int TSIZE = NCOL * NRUN;

  typedef struct packed {
    logic [TBL_W-1:0] min_cost;
    logic             feasible;
  } answer_t;

  logic [7:0]        num_colors_q, target_runs_q;
  logic [COST_W-1:0] color_cost [NCOL];
  logic [TBL_W-1:0]  best_prev [TSIZE];
  logic [TBL_W-1:0]  best_cur [TSIZE];
  answer_t           answers_q [$];

  assign pending = answers_q.size();

  function automatic void relax_entry(int col, int runs, logic [TBL_W-1:0] val);
    int idx;
    idx = (col - 1) * NRUN + (runs - 1);
    if (val < best_cur[idx]) best_cur[idx] = val;
  endfunction

  // Fold one position into the (last color, runs) table.
  function automatic void fold_position(int fixed, bit first);
    int nc, nr, r;
    bit preset_ok;
    logic [TBL_W-1:0] base;
    logic [TBL_W:0] sum;
    nc = (num_colors_q > NCOL) ? NCOL : num_colors_q;
    nr = (target_runs_q > NRUN) ? NRUN : target_runs_q;
    preset_ok = (fixed >= 1) && (fixed <= nc);
    for (int i = 0; i < TSIZE; i++) best_cur[i] = INF_COST;
    if (nr >= 1) begin
      if (first) begin
        if (fixed != 0) begin
          if (preset_ok) relax_entry(fixed, 1, '0);
        end else begin
          for (int v = 1; v <= nc; v++) relax_entry(v, 1, TBL_W'(color_cost[v-1]));
        end
      end else begin
        for (int j = 1; j <= nc; j++) begin
          for (int u = 1; u <= nr; u++) begin
            base = best_prev[(j-1)*NRUN + (u-1)];
            if (base == INF_COST) continue;
            if (fixed != 0) begin
              if (preset_ok) begin
                r = u + ((fixed != j) ? 1 : 0);
                if (r <= nr) relax_entry(fixed, r, base);
              end
            end else begin
              for (int v = 1; v <= nc; v++) begin
                r = u + ((v != j) ? 1 : 0);
                if (r <= nr) begin
                  sum = {1'b0, base} + color_cost[v-1];
                  // saturate one below the sentinel
                  relax_entry(v, r, (sum >= INF_COST) ? INF_COST - 1 : sum[TBL_W-1:0]);
                end
              end
            end
          end
        end
      end
    end
    for (int i = 0; i < TSIZE; i++) best_prev[i] = best_cur[i];
  endfunction

  function automatic answer_t row_answer();
    answer_t a;
    logic [TBL_W-1:0] best;
    int nc;
    best = INF_COST;
    nc = (num_colors_q > NCOL) ? NCOL : num_colors_q;
    if (target_runs_q >= 1 && target_runs_q <= NRUN)
      for (int v = 1; v <= nc; v++)
        if (best_prev[(v-1)*NRUN + target_runs_q - 1] < best)
          best = best_prev[(v-1)*NRUN + target_runs_q - 1];
    a.feasible = (best != INF_COST);
    a.min_cost = a.feasible ? best : '0;
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      num_colors_q  <= 8'd1;
      target_runs_q <= 8'd1;
      for (int i = 0; i < TSIZE; i++) begin
        best_prev[i] = INF_COST;
        best_cur[i]  = INF_COST;
      end
      for (int i = 0; i < NCOL; i++) color_cost[i] = '0;
      answers_q.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_NUM_COLORS) num_colors_q <= pwdata[7:0];
        else if (paddr == ADDR_TARGET_RUNS) target_runs_q <= pwdata[7:0];
      end
      if (in_valid && !in_stall) begin
        if (in_color >= 1 && in_color <= NCOL) color_cost[in_color-1] = in_paint_cost;
        if (in_last_color) begin
          fold_position(in_fixed_color, in_first_position);
          if (in_last_position) answers_q.push_back(row_answer());
        end
      end
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result: min_cost=%0d feasible=%0b", out_min_cost,
                     out_feasible);
          errors <= errors + 1;
        end else begin
          want = answers_q.pop_front();
          if (want.min_cost !== out_min_cost || want.feasible !== out_feasible) begin
            if (errors < 10)
              $display("result mismatch: expected min_cost=%0d feasible=%0b, got %0d %0b",
                       want.min_cost, want.feasible, out_min_cost, out_feasible);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

@@ sim/min_cost_coloring_k_runs_top_test.sv @@
// Stimulus and verdict for the exact-k-runs min-cost coloring block.
// Uses mcck_pkg, min_cost_coloring_k_runs_top and min_cost_coloring_k_runs_checker.
`timescale 1ns / 1ps
module min_cost_coloring_k_runs_top_test;
  import mcck_pkg::*;

  localparam int QUIET_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_fixed_color = '0;
  logic [7:0] in_color = '0;
  logic [COST_W-1:0] in_paint_cost = '0;
  logic in_first_position = 1'b0;
  logic in_last_color = 1'b0;
  logic in_last_position = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TBL_W-1:0] out_min_cost;
  logic out_feasible;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  int errors, pending;
  int num_colors = 1, target_runs = 1;
  int sent_items = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  min_cost_coloring_k_runs_top dut (.*);

  min_cost_coloring_k_runs_checker scoreboard (.*);

  // receiver back-pressure in short bursts
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int colors_used();
    return (num_colors > 128) ? 128 : num_colors;
  endfunction

  function automatic int pass_cycles();
    int nr;
    nr = (target_runs > 128) ? 128 : target_runs;
    return ((colors_used() < 1) ? 1 : colors_used()) * ((nr < 1) ? 1 : nr) + 10;
  endfunction

  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0: return '1;
      1: return '0;
      2, 3, 4: return COST_W'($urandom);
      default: return COST_W'($urandom_range(0, 50));
    endcase
  endfunction

  function automatic logic [7:0] pick_fixed();
    int r;
    r = $urandom_range(0, 9);
    if (r <= 5 || colors_used() == 0) return 8'd0;
    if (r <= 8) return 8'($urandom_range(1, colors_used()));
    return 8'($urandom_range(0, 255));
  endfunction

  // entered just after a rising edge; returns just after the accepting edge
  task automatic send(logic [7:0] fixed, logic [7:0] col, logic [COST_W-1:0] cost,
                      bit first, bit lastc, bit lastp);
    bit busy;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_fixed_color <= fixed;
    in_color <= col;
    in_paint_cost <= cost;
    in_first_position <= first;
    in_last_color <= lastc;
    in_last_position <= lastp;
    do begin
      @(negedge clk);
      busy = in_stall;
      @(posedge clk);
    end while (busy);
    if ((col >= 1 && col <= 128) || lastc) sent_items++;
  endtask

  // one position: every color in use once, in shuffled order, plus some stray colors
  task automatic position(logic [7:0] fixed, bit first, bit lastp);
    int order[128];
    int n, k, tmp;
    n = colors_used();
    if (n == 0) begin
      send(fixed, 8'($urandom_range(0, 255)), pick_cost(), first, 1'b1, lastp);
    end else begin
      for (int i = 0; i < n; i++) order[i] = i + 1;
      for (int i = n - 1; i > 0; i--) begin
        k = $urandom_range(0, i);
        tmp = order[i]; order[i] = order[k]; order[k] = tmp;
      end
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0)
          send(fixed, ($urandom_range(0, 1) == 1) ? 8'd0 : 8'($urandom_range(129, 255)),
               pick_cost(), first, 1'b0, lastp);
        send(fixed, 8'(order[i]), pick_cost(), first, i == n - 1, lastp);
      end
    end
  endtask

  task automatic row(int npos, bit with_first, bit with_last);
    for (int p = 0; p < npos; p++)
      position(pick_fixed(), with_first && p == 0, with_last && p == npos - 1);
  endtask

  // let the last sweep finish, then wait until every expected result is taken
  task automatic wait_drained();
    in_valid <= 1'b0;
    repeat (pass_cycles()) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_AW-1:0] addr, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(int nc, int tr);
    wait_drained();
    reg_write(ADDR_NUM_COLORS, nc);
    reg_write(ADDR_TARGET_RUNS, tr);
    num_colors = nc;
    target_runs = tr;
  endtask

  int corner_nc[6] = '{128, 128, 1, 0, 200, 2};
  int corner_tr[6] = '{128, 1, 128, 3, 200, 0};

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // a row that never had a first position sees an empty table, then two one-position rows
    send(8'd0, 8'd1, 30'd5, 1'b0, 1'b1, 1'b1);
    send(8'd0, 8'd1, '1, 1'b1, 1'b1, 1'b1);
    send(8'd1, 8'd1, 30'd9, 1'b1, 1'b1, 1'b1);

    configure(3, 2);
    send(8'd0, 8'd0, 30'd77, 1'b0, 1'b0, 1'b0);
    send(8'd0, 8'd255, '1, 1'b0, 1'b0, 1'b0);
    position(8'd2, 1'b1, 1'b0);
    position(8'd0, 1'b0, 1'b0);
    position(8'd3, 1'b0, 1'b1);
    // preset color beyond the colors in use poisons the row
    position(8'd0, 1'b1, 1'b0);
    position(8'd7, 1'b0, 1'b1);
    position(8'd0, 1'b1, 1'b1);

    for (int c = 0; c < 6; c++) begin
      configure(corner_nc[c], corner_tr[c]);
      row((corner_nc[c] >= 128) ? 2 : 3, 1'b1, 1'b1);
    end

    while (sent_items < 1050) begin
      configure($urandom_range(1, 5), $urandom_range(1, 6));
      repeat ($urandom_range(3, 6)) begin
        if (sent_items > 950) calm = 1'b1;
        case ($urandom_range(0, 9))
          0: row($urandom_range(1, 4), 1'b1, 1'b0);
          1: row($urandom_range(1, 3), 1'b0, 1'b1);
          default: row($urandom_range(1, 6), 1'b1, 1'b1);
        endcase
      end
    end

    calm = 1'b1;
    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
